@@ src/assert_macros.svh @@
// Assertion macros shared by the projection pipeline modules.
// Each macro expands to one labeled concurrent assertion on the given clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWTS_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWTS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

@@ src/pwts_pkg.sv @@
// Shared types and constants for the world-to-screen projection pipeline.
// No dependencies; used by the top level, pwts_scale, pwts_div_step and the checker.
package pwts_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_ROW0_C01 = 8'd0;
  localparam logic [7:0] REG_ROW0_C23 = 8'd1;
  localparam logic [7:0] REG_ROW1_C01 = 8'd2;
  localparam logic [7:0] REG_ROW1_C23 = 8'd3;
  localparam logic [7:0] REG_ROW3_C01 = 8'd4;
  localparam logic [7:0] REG_ROW3_C23 = 8'd5;
  localparam logic [7:0] REG_WIDTH    = 8'd6;
  localparam logic [7:0] REG_HEIGHT   = 8'd7;

  // Near limit 0.1 in Q16.16, moved to the Q34.30 clip scale.
  localparam logic signed [63:0] NEAR_Q30 = 64'sd6554 * 64'sd16384;

  localparam int unsigned QBITS = 16;

  // One division lane: partial remainder and the shift word that feeds
  // dividend bits in from the top and collects quotient bits at the bottom.
  typedef struct packed {
    logic [63:0]      rem;
    logic [QBITS-1:0] nq;
  } lane_t;

  typedef struct packed {
    logic        vld;
    logic        on;
    logic [62:0] w;
    lane_t       x;
    lane_t       y;
  } div_t;

endpackage

@@ src/perspective_world_to_screen.sv @@
// Top level of the world-to-screen projection pipeline: configuration registers,
// stream handshake and the divider chain. Depends on pwts_pkg, pwts_clip,
// pwts_scale, pwts_div_step and assert_macros.svh.
//
// Usage:
//   The input stream carries one world point per transfer (x, y, z, signed
//   Q16.16). The output stream returns one result per point: pixel x and y in
//   unsigned Q12.4 on tdata and the on-screen flag on tuser; an off-screen
//   point comes out with both coordinates zero.
//   The configuration channel writes the six matrix words and the viewport
//   size by index; it is always ready, indexes above seven are ignored. Write
//   it only while the pipeline is empty.
//   Stages in order: the matrix products, the row sums, culling, dividend
//   scaling, then the divider with one quotient bit per stage. A new point is
//   taken every cycle while the receiver does not stall.
//   Reset empties the pipeline and loads the identity rows and a 1920 by
//   1080 viewport. When the receiver stalls with a result pending, the whole
//   pipeline holds and s_axis_tready drops in the same cycle; nothing is
//   dropped or repeated.
`include "assert_macros.svh"

module perspective_world_to_screen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // world_x [31:0], world_y [63:32], world_z [95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // screen_x [15:0], screen_y [31:16]
  output logic        m_axis_tuser,  // on_screen [0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned NSTEPS = pwts_pkg::QBITS;

  logic [63:0] r0a_q, r0b_q, r1a_q, r1b_q, r3a_q, r3b_q;
  logic [11:0] width_q, height_q;
  logic        en;
  logic        c_vld;
  logic signed [63:0] cx, cy, cw;
  pwts_pkg::div_t st [NSTEPS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0a_q    <= 64'h0000_0000_0001_0000;
      r0b_q    <= '0;
      r1a_q    <= 64'h0001_0000_0000_0000;
      r1b_q    <= '0;
      r3a_q    <= '0;
      r3b_q    <= 64'h0001_0000_0000_0000;
      width_q  <= 12'd1920;
      height_q <= 12'd1080;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwts_pkg::REG_ROW0_C01: r0a_q    <= cfg_data_i;
        pwts_pkg::REG_ROW0_C23: r0b_q    <= cfg_data_i;
        pwts_pkg::REG_ROW1_C01: r1a_q    <= cfg_data_i;
        pwts_pkg::REG_ROW1_C23: r1b_q    <= cfg_data_i;
        pwts_pkg::REG_ROW3_C01: r3a_q    <= cfg_data_i;
        pwts_pkg::REG_ROW3_C23: r3b_q    <= cfg_data_i;
        pwts_pkg::REG_WIDTH:    width_q  <= cfg_data_i[11:0];
        pwts_pkg::REG_HEIGHT:   height_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances as one unit whenever the output slot is empty or its result is taken.
  assign en            = !st[NSTEPS].vld || m_axis_tready;
  assign s_axis_tready = en;

  pwts_clip u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .x_i    ($signed(s_axis_tdata[31:0])),
    .y_i    ($signed(s_axis_tdata[63:32])),
    .z_i    ($signed(s_axis_tdata[95:64])),
    .r0a_i  (r0a_q),
    .r0b_i  (r0b_q),
    .r1a_i  (r1a_q),
    .r1b_i  (r1b_q),
    .r3a_i  (r3a_q),
    .r3b_i  (r3b_q),
    .vld_o  (c_vld),
    .cx_o   (cx),
    .cy_o   (cy),
    .cw_o   (cw)
  );

  pwts_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (c_vld),
    .cx_i     (cx),
    .cy_i     (cy),
    .cw_i     (cw),
    .width_i  (width_q),
    .height_i (height_q),
    .div_o    (st[0])
  );

  for (genvar i = 0; i < NSTEPS; i++) begin : g_div
    pwts_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (st[i]),
      .div_o  (st[i+1])
    );
  end

  assign m_axis_tvalid = st[NSTEPS].vld;
  assign m_axis_tdata  = {st[NSTEPS].y.nq, st[NSTEPS].x.nq};
  assign m_axis_tuser  = st[NSTEPS].on;

  `PWTS_ASSERT_IMPL(a_off_is_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)
  `PWTS_ASSERT_IMPL(a_x_in_width, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:0] <= {width_q, 4'b0})
  `PWTS_ASSERT_IMPL(a_y_in_height, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:16] <= {height_q, 4'b0})

endmodule

@@ src/pwts_clip.sv @@
// Clip-space transform: nine products in the first stage, row sums in the second.
// Depends on no package and no other modules.
module pwts_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  input  logic [63:0]        r0a_i,
  input  logic [63:0]        r0b_i,
  input  logic [63:0]        r1a_i,
  input  logic [63:0]        r1b_i,
  input  logic [63:0]        r3a_i,
  input  logic [63:0]        r3b_i,
  output logic               vld_o,
  output logic signed [63:0] cx_o,
  output logic signed [63:0] cy_o,
  output logic signed [63:0] cw_o
);

  logic               vld_a_q, vld_b_q;
  logic signed [63:0] p_d [9];
  logic signed [63:0] p_q [9];
  logic signed [63:0] cx_d, cy_d, cw_d;
  logic signed [63:0] cx_q, cy_q, cw_q;

  always_comb begin
    p_d[0] = x_i * $signed(r0a_i[31:0]);
    p_d[1] = y_i * $signed(r0a_i[63:32]);
    p_d[2] = z_i * $signed(r0b_i[31:0]);
    p_d[3] = x_i * $signed(r1a_i[31:0]);
    p_d[4] = y_i * $signed(r1a_i[63:32]);
    p_d[5] = z_i * $signed(r1b_i[31:0]);
    p_d[6] = x_i * $signed(r3a_i[31:0]);
    p_d[7] = y_i * $signed(r3a_i[63:32]);
    p_d[8] = z_i * $signed(r3b_i[31:0]);
  end

  // Arithmetic shift right by two is the floor of a quarter.
  always_comb begin
    cx_d = (p_q[0] >>> 2) + (p_q[1] >>> 2) + (p_q[2] >>> 2)
         + $signed({{18{r0b_i[63]}}, r0b_i[63:32], 14'b0});
    cy_d = (p_q[3] >>> 2) + (p_q[4] >>> 2) + (p_q[5] >>> 2)
         + $signed({{18{r1b_i[63]}}, r1b_i[63:32], 14'b0});
    cw_d = (p_q[6] >>> 2) + (p_q[7] >>> 2) + (p_q[8] >>> 2)
         + $signed({{18{r3b_i[63]}}, r3b_i[63:32], 14'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= p_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
      cw_q <= cw_d;
    end
  end

  assign vld_o = vld_b_q;
  assign cx_o  = cx_q;
  assign cy_o  = cy_q;
  assign cw_o  = cw_q;

endmodule

@@ src/pwts_scale.sv @@
// Culling against the near limit and viewport, then scaling of the dividends.
// Depends on pwts_pkg for the near limit and the divider record type.
module pwts_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [63:0] cx_i,
  input  logic signed [63:0] cy_i,
  input  logic signed [63:0] cw_i,
  input  logic [11:0]        width_i,
  input  logic [11:0]        height_i,
  output pwts_pkg::div_t     div_o
);

  logic        vld_q;
  logic        on_d, on_q;
  logic [63:0] tx_d, ty_d;
  logic [62:0] tx_q, ty_q, w_q;
  logic [77:0] nx, ny;
  logic [79:0] nx_d, ny_d;
  pwts_pkg::div_t div_d, div_q;

  always_comb begin
    on_d = (cw_i >= pwts_pkg::NEAR_Q30) && !(cx_i < -cw_i) && !(cx_i > cw_i)
        && !(cy_i < -cw_i) && !(cy_i > cw_i);
    tx_d = 64'(cx_i + cw_i);
    ty_d = 64'(cw_i - cy_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      on_q <= on_d;
      tx_q <= tx_d[62:0];
      ty_q <= ty_d[62:0];
      w_q  <= cw_i[62:0];
    end
  end

  // Off-screen points feed a zero dividend over a divisor of one, so their
  // quotient comes out zero whatever clip w was.
  always_comb begin
    nx     = tx_q * {width_i, 3'b0};
    ny     = ty_q * {height_i, 3'b0};
    nx_d   = on_q ? {2'b0, nx} : '0;
    ny_d   = on_q ? {2'b0, ny} : '0;
    div_d.vld   = vld_q;
    div_d.on    = on_q;
    div_d.w     = on_q ? w_q : 63'd1;
    div_d.x.rem = nx_d[79:16];
    div_d.x.nq  = nx_d[15:0];
    div_d.y.rem = ny_d[79:16];
    div_d.y.nq  = ny_d[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

@@ src/pwts_div_step.sv @@
// One registered restoring-division step for both lanes of the divider.
// Depends on pwts_pkg for the divider record and assert_macros.svh for checks.
`include "assert_macros.svh"

module pwts_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  pwts_pkg::div_t div_i,
  output pwts_pkg::div_t div_o
);

  pwts_pkg::div_t div_d, div_q;
  logic [63:0]    rx, ry;
  logic           gx, gy;

  always_comb begin
    rx = {div_i.x.rem[62:0], div_i.x.nq[pwts_pkg::QBITS-1]};
    ry = {div_i.y.rem[62:0], div_i.y.nq[pwts_pkg::QBITS-1]};
    gx = rx >= {1'b0, div_i.w};
    gy = ry >= {1'b0, div_i.w};
    div_d = div_i;
    div_d.x.rem = gx ? rx - {1'b0, div_i.w} : rx;
    div_d.y.rem = gy ? ry - {1'b0, div_i.w} : ry;
    div_d.x.nq  = {div_i.x.nq[pwts_pkg::QBITS-2:0], gx};
    div_d.y.nq  = {div_i.y.nq[pwts_pkg::QBITS-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

  // The partial remainder must stay below the divisor after every step.
  `PWTS_ASSERT_IMPL(a_rem_x_below_w, clk_i, rst_ni, div_q.vld, div_q.x.rem < {1'b0, div_q.w})
  `PWTS_ASSERT_IMPL(a_rem_y_below_w, clk_i, rst_ni, div_q.vld, div_q.y.rem < {1'b0, div_q.w})

endmodule

@@ dv/pwts_checker.sv @@
// Checker for the world-to-screen projection block: predicts each result from
// the accepted input transfers and compares it with the output stream.
// Depends on pwts_pkg for the register indexes and the near limit.
module pwts_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          onscreen_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        on;
  } pixel_t;

  logic [63:0] matrix_q[6];
  logic [11:0] width_q, height_q;
  pixel_t      pixel_queue[$];

  function automatic logic signed [63:0] entry(input logic [63:0] w, input bit hi);
    logic [31:0] h;
    h = hi ? w[63:32] : w[31:0];
    return {{32{h[31]}}, h};
  endfunction

  function automatic logic signed [63:0] clip_sum(input logic [63:0] r01, input logic [63:0] r23,
                                                  input logic signed [63:0] x,
                                                  input logic signed [63:0] y,
                                                  input logic signed [63:0] z);
    logic signed [63:0] s;
    s = (x * entry(r01, 0)) >>> 2;
    s += (y * entry(r01, 1)) >>> 2;
    s += (z * entry(r23, 0)) >>> 2;
    s += entry(r23, 1) * 64'sd16384;
    return s;
  endfunction

  function automatic pixel_t project(input logic [95:0] d);
    logic signed [63:0] x, y, z, cx, cy, cw;
    logic [127:0] nx, ny;
    pixel_t p;
    x = {{32{d[31]}}, d[31:0]};
    y = {{32{d[63]}}, d[63:32]};
    z = {{32{d[95]}}, d[95:64]};
    cx = clip_sum(matrix_q[0], matrix_q[1], x, y, z);
    cy = clip_sum(matrix_q[2], matrix_q[3], x, y, z);
    cw = clip_sum(matrix_q[4], matrix_q[5], x, y, z);
    p = '0;
    if (cw < pwts_pkg::NEAR_Q30) return p;
    if (cx < -cw || cx > cw || cy < -cw || cy > cw) return p;
    nx = 128'(cx + cw) * (128'(width_q) * 8);
    ny = 128'(cw - cy) * (128'(height_q) * 8);
    p.sx = 16'(nx / 128'(cw));
    p.sy = 16'(ny / 128'(cw));
    p.on = 1'b1;
    return p;
  endfunction

  assign pending_o = pixel_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      matrix_q[0] <= 64'h1_0000;
      matrix_q[1] <= '0;
      matrix_q[2] <= 64'h1 << 48;
      matrix_q[3] <= '0;
      matrix_q[4] <= '0;
      matrix_q[5] <= 64'h1 << 48;
      width_q <= 12'd1920;
      height_q <= 12'd1080;
      pixel_queue.delete();
      fail_count_o <= 0;
      onscreen_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
        if (pixel_queue.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("ERROR: expected sx=%0d sy=%0d on=%0d, got sx=%0d sy=%0d on=%0d",
                       want.sx, want.sy, want.on, got.sx, got.sy, got.on);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.on) onscreen_count_o <= onscreen_count_o + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) pixel_queue.push_back(project(s_axis_tdata));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pwts_pkg::REG_ROW0_C01, pwts_pkg::REG_ROW0_C23, pwts_pkg::REG_ROW1_C01,
          pwts_pkg::REG_ROW1_C23, pwts_pkg::REG_ROW3_C01, pwts_pkg::REG_ROW3_C23:
            matrix_q[cfg_index_i] <= cfg_data_i;
          pwts_pkg::REG_WIDTH: width_q <= cfg_data_i[11:0];
          pwts_pkg::REG_HEIGHT: height_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ dv/testbench.sv @@
// Top of the projection testbench: clock, reset, configuration phases and
// point stimulus. Depends on pwts_pkg, the block and pwts_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [31:0] m_axis_tdata;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  int fail_count, pending, onscreen_count, points_sent = 0, cycles = 0;
  bit stall_mode = 0;

  perspective_world_to_screen u_dut (.*);
  pwts_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending),
                          .onscreen_count_o(onscreen_count));

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stall pattern: alternate light-stall and heavy-stall stretches.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q16(input int v);
    return 32'(v <<< 16);
  endfunction

  function automatic logic [63:0] pair(input logic [31:0] lo, input logic [31:0] hi);
    return {hi, lo};
  endfunction

  // Sends one point; holds tvalid high when the next call follows at once.
  task automatic send_point(input logic [95:0] d);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
    @(negedge clk_i);
  endtask

  // The gap is never empty, so tvalid really drops between bursts.
  task automatic end_burst();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
      2: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_points(input int n, input bit scene);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (left > 0) begin
          if (scene && $urandom_range(0, 9) != 0)
            send_point({q16($urandom_range(1, 40)) ^ ($urandom & 32'hffff),
                        32'($signed($urandom_range(0, 30 << 16)) - (15 << 16)),
                        32'($signed($urandom_range(0, 30 << 16)) - (15 << 16))});
          else
            send_point({rnd_coord(), rnd_coord(), rnd_coord()});
          left--;
        end
      end
      end_burst();
    end
  endtask

  task automatic random_matrix();
    for (int r = 0; r < 6; r++)
      write_reg(8'(r), pair($urandom, $urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed points under the reset identity matrix and 1920x1080 viewport.
    send_point({q16(1), q16(0), q16(0)});
    send_point({q16(1), q16(1), q16(1)});
    send_point({q16(1), q16(-1), q16(-1)});
    send_point({q16(1), q16(2), q16(0)});
    send_point({q16(1), q16(0), q16(-2)});
    send_point({32'd6554, 32'd0, 32'd0});
    send_point({32'd6553, 32'd0, 32'd0});
    send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_point({32'h7fff_ffff, 32'h8000_0000, 32'd0});
    send_point({q16(-1), q16(0), q16(0)});
    send_point({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    end_burst();
    drain();

    // Extreme viewport sizes, and an index outside the register file.
    write_reg(pwts_pkg::REG_WIDTH, 64'hffff_ffff_ffff_f001);
    write_reg(pwts_pkg::REG_HEIGHT, 64'h0fff);
    write_reg(8'hff, 64'h1234);
    send_point({q16(1), q16(1), q16(-1)});
    send_point({q16(1), q16(0), q16(0)});
    end_burst();
    drain();
    write_reg(pwts_pkg::REG_WIDTH, 64'd1);
    write_reg(pwts_pkg::REG_HEIGHT, 64'h1000);
    send_point({q16(1), q16(1), q16(1)});
    send_point({q16(2), q16(-1), q16(1)});
    end_burst();
    drain();

    // Perspective camera looking down +x with w taken from x.
    write_reg(pwts_pkg::REG_ROW0_C01, pair(32'd0, q16(1)));
    write_reg(pwts_pkg::REG_ROW0_C23, pair(q16(0), 32'h0000_8000));
    write_reg(pwts_pkg::REG_ROW1_C01, pair(32'd0, 32'd0));
    write_reg(pwts_pkg::REG_ROW1_C23, pair(q16(1), 32'hffff_8000));
    write_reg(pwts_pkg::REG_ROW3_C01, pair(q16(1), 32'd0));
    write_reg(pwts_pkg::REG_ROW3_C23, pair(32'd0, 32'h0000_4000));
    write_reg(pwts_pkg::REG_WIDTH, 64'd640);
    write_reg(pwts_pkg::REG_HEIGHT, 64'd480);
    random_points(500, 1);
    drain();

    // Extreme matrix words.
    for (int r = 0; r < 6; r++) write_reg(8'(r), {32'h8000_0000, 32'h7fff_ffff});
    send_point({q16(1), q16(1), q16(1)});
    send_point({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    end_burst();
    drain();

    random_matrix();
    write_reg(pwts_pkg::REG_WIDTH, 64'($urandom_range(1, 4095)));
    write_reg(pwts_pkg::REG_HEIGHT, 64'($urandom_range(1, 4095)));
    random_points(300, 0);
    drain();

    write_reg(pwts_pkg::REG_ROW0_C01, pair(q16(1), 32'd0));
    write_reg(pwts_pkg::REG_ROW0_C23, pair(32'd0, 32'd0));
    write_reg(pwts_pkg::REG_ROW1_C01, pair(32'd0, q16(1)));
    write_reg(pwts_pkg::REG_ROW1_C23, pair(32'd0, 32'd0));
    write_reg(pwts_pkg::REG_ROW3_C01, pair(32'd0, 32'd0));
    write_reg(pwts_pkg::REG_ROW3_C23, pair(32'd0, q16(20)));
    write_reg(pwts_pkg::REG_WIDTH, 64'd4095);
    write_reg(pwts_pkg::REG_HEIGHT, 64'd1);
    random_points(620, 1);
    drain();

    $display("Sent %0d points over several matrix and viewport settings; %0d landed on screen.",
             points_sent, onscreen_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
